### rtl/owsm_pkg.sv
// owsm_pkg: shared types, widths and constants of the omni wheel speed mixer.
// Holds the quarter-wave sine table, built at elaboration by a constant function.
// No dependencies; every rtl module imports it.
`timescale 1ns / 1ps
`default_nettype none

package owsm_pkg;

  // Trig table geometry
  localparam int SINE_TABLE_BITS = 8;
  localparam int TRIG_FRAC_BITS  = 15;
  localparam int SINE_N          = 1 << SINE_TABLE_BITS;
  localparam int IDX_W           = SINE_TABLE_BITS + 1;
  localparam int ROM_W           = TRIG_FRAC_BITS + 1;   // 0 .. 2^T
  localparam int TRIG_W          = TRIG_FRAC_BITS + 2;   // signed sin / cos
  localparam int ANG_W           = 16;
  localparam int OFF_W           = ANG_W - 2;            // offset within a quadrant

  // Field widths
  localparam int VEL_W      = 16;
  localparam int OFS_W      = 10;
  localparam int GAIN_W     = 24;
  localparam int WHEEL_W    = 24;
  localparam int NUM_WHEELS = 4;

  // Datapath widths
  localparam int PROD_W  = VEL_W + TRIG_W;          // velocity * trig
  localparam int ROT_W   = PROD_W + 1;              // robot-frame velocity, Q(T)
  localparam int OW_W    = OFS_W + VEL_W + 1;       // offset * yaw rate
  localparam int SQ3H_W  = 16;
  localparam int T_W     = ROT_W + SQ3H_W;          // 0.866 term
  localparam int A_W     = T_W + 1;                 // halved Q16 mix sum
  localparam int HALF_SH = 14;                      // 0.5 in halved Q16
  localparam int ONE_SH  = 15;                      // 1.0 in halved Q16
  localparam int DW_SH   = TRIG_FRAC_BITS + 12;     // yaw term alignment
  localparam int Q_W     = VEL_W + TRIG_FRAC_BITS + 25;
  localparam int X_SH    = TRIG_FRAC_BITS + 7;      // power-of-two part of divisor
  localparam int X_W     = VEL_W + 17;              // dividend of the /125 step
  localparam int QT_W    = X_W - 6;                 // X / 125 fits here
  localparam int RECIP_W = X_W - 6;
  localparam int SURF_W  = QT_W + 1;                // surface speed, Q8 mm/s
  localparam int PRD_W   = SURF_W + GAIN_W + 1;
  localparam int OUT_SH  = 24;
  localparam int RND_W   = PRD_W - OUT_SH;

  // Divisor 1000 * 2^(T+8) reduces to 125 * 2^(T+7) after common factors
  localparam int SPLIT_DIV = 125;
  localparam logic [Q_W-1:0] ROUND_X =
    Q_W'(SPLIT_DIV) << (TRIG_FRAC_BITS + 6);
  localparam logic [RECIP_W-1:0] RECIP_125 =
    RECIP_W'((64'd1 << X_W) / 64'd125);

  // 0.866 in Q16 is 56754; the mix works on halved coefficients
  localparam logic signed [SQ3H_W-1:0] COEF_SQ3H_HALF = 16'sd28377;

  // Wheel 4 adds the yaw term, the others subtract it
  localparam logic [NUM_WHEELS-1:0] YAW_PLUS = 4'b1000;

  localparam logic signed [WHEEL_W-1:0] SAT_MAX = {1'b0, {(WHEEL_W-1){1'b1}}};
  localparam logic signed [WHEEL_W-1:0] SAT_MIN = {1'b1, {(WHEEL_W-1){1'b0}}};

  // Configuration registers
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = GAIN_W;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_OFFSET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_GAIN     = 8'd1;
  localparam logic [OFS_W-1:0]     OFS_RESET        = 10'd150;
  localparam logic [GAIN_W-1:0]    GAIN_RESET       = 24'd1251677;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Item types
  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] yaw_rate;
    logic [ANG_W-1:0]        heading;
  } in_item_t;

  typedef struct packed {
    logic signed [WHEEL_W-1:0] wheel_one;
    logic signed [WHEEL_W-1:0] wheel_two;
    logic signed [WHEEL_W-1:0] wheel_three;
    logic signed [WHEEL_W-1:0] wheel_four;
    logic                      clipped;
  } out_item_t;

  // Between rotation and mixing
  typedef struct packed {
    logic signed [ROT_W-1:0] px;
    logic signed [ROT_W-1:0] py;
    logic signed [OW_W-1:0]  ow;
  } rot_t;

  // Between mixing and scaling: magnitude before /125, and sign
  typedef struct packed {
    logic [NUM_WHEELS-1:0][X_W-1:0] x;
    logic [NUM_WHEELS-1:0]          neg;
  } mix_t;

  typedef logic [SINE_N:0][ROM_W-1:0] sine_rom_t;

  // Quarter-wave sine, Taylor series to x^15 in Q30, floored terms
  function automatic sine_rom_t build_sine();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] prod;
    longint      sum;
    longint      v;
    int          i;
    int          k;
    rom = '0;
    for (i = 0; i <= SINE_N; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (k = 1; k <= 7; k++) begin
        prod = (term * x2) >> 30;
        case (k)
          1:       term = prod / 64'd6;
          2:       term = prod / 64'd20;
          3:       term = prod / 64'd42;
          4:       term = prod / 64'd72;
          5:       term = prod / 64'd110;
          6:       term = prod / 64'd156;
          default: term = prod / 64'd210;
        endcase
        if ((k & 1) != 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum + (longint'(1) <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
      if (v > (longint'(1) <<< TRIG_FRAC_BITS)) begin
        v = longint'(1) <<< TRIG_FRAC_BITS;
      end
      rom[i] = ROM_W'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

endpackage

`default_nettype wire

### rtl/omni_wheel_speed_mixer.sv
// omni_wheel_speed_mixer: four-wheel omni base inverse kinematics, heading to wheel RPM.
// Pipeline: 11 register stages. Throughput: one item per cycle, set by the fully pipelined
// datapath (3 rotation, 4 mixing, 4 scaling stages); stalls only back up from out_ready_i.
// Reset: clears all stage valid bits and loads wheel_offset_mm = 150, rpm_gain = 1251677.
// Depends on owsm_pkg, owsm_rotate, owsm_mix, owsm_scale.
`timescale 1ns / 1ps
`default_nettype none

module omni_wheel_speed_mixer import owsm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers
  logic [OFS_W-1:0]  ofs_q;
  logic [OFS_W-1:0]  ofs_d;
  logic [GAIN_W-1:0] gain_q;
  logic [GAIN_W-1:0] gain_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    ofs_d  = ofs_q;
    gain_d = gain_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WHEEL_OFFSET: ofs_d  = cfg_data_i[OFS_W-1:0];
        CFG_RPM_GAIN:     gain_d = cfg_data_i[GAIN_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q  <= OFS_RESET;
      gain_q <= GAIN_RESET;
    end else begin
      ofs_q  <= ofs_d;
      gain_q <= gain_d;
    end
  end

  // Datapath
  logic rot_valid;
  logic rot_ready;
  rot_t rot_data;
  logic mix_valid;
  logic mix_ready;
  mix_t mix_data;

  owsm_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .ofs_i   (ofs_q),
    .valid_o (rot_valid),
    .ready_i (rot_ready),
    .data_o  (rot_data)
  );

  owsm_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_valid),
    .ready_o (rot_ready),
    .data_i  (rot_data),
    .valid_o (mix_valid),
    .ready_i (mix_ready),
    .data_o  (mix_data)
  );

  owsm_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mix_valid),
    .ready_o (mix_ready),
    .data_i  (mix_data),
    .gain_i  (gain_q),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  // A clipped item has at least one wheel at a rail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clipped |->
      out_data_o.wheel_one == SAT_MAX || out_data_o.wheel_one == SAT_MIN ||
      out_data_o.wheel_two == SAT_MAX || out_data_o.wheel_two == SAT_MIN ||
      out_data_o.wheel_three == SAT_MAX || out_data_o.wheel_three == SAT_MIN ||
      out_data_o.wheel_four == SAT_MAX || out_data_o.wheel_four == SAT_MIN)
    else $error("clipped flag set with no wheel saturated");

  // Input backpressure only comes from a held result at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while the output side is free");

endmodule

`default_nettype wire

### rtl/owsm_rotate.sv
// owsm_rotate: heading lookup and rotation of the field velocity into the robot frame.
// Three register stages: trig lookup, products, sums. Also forms offset * yaw rate.
// Depends on owsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module owsm_rotate import owsm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire in_item_t         data_i,
  input  wire logic [OFS_W-1:0] ofs_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output rot_t                  data_o
);

  logic [2:0] vld_q;
  logic [3:0] adv;

  // Stage advance: a stage moves when empty or when the next one moves
  always_comb begin
    adv[3] = ready_i;
    adv[2] = !vld_q[2] || adv[3];
    adv[1] = !vld_q[1] || adv[2];
    adv[0] = !vld_q[0] || adv[1];
  end

  assign ready_o = adv[0];
  assign valid_o = vld_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
    end
  end

  // Stage 1: quadrant, rounded table index, sin and cos
  logic [1:0]               quad;
  logic [OFF_W:0]           off_rnd;
  logic [IDX_W-1:0]         idx_r;
  logic [IDX_W-1:0]         idx_s;
  logic [IDX_W-1:0]         idx_c;
  logic [ROM_W-1:0]         s_mag;
  logic [ROM_W-1:0]         c_mag;
  logic signed [TRIG_W-1:0] sin_d;
  logic signed [TRIG_W-1:0] cos_d;

  always_comb begin
    quad    = data_i.heading[ANG_W-1 -: 2];
    off_rnd = {1'b0, data_i.heading[OFF_W-1:0]}
            + ((OFF_W+1)'(1) << (OFF_W - 1 - SINE_TABLE_BITS));
    idx_r   = off_rnd[OFF_W -: IDX_W];
    // odd quadrants read the table backwards; cos is one quadrant ahead
    idx_s   = quad[0] ? IDX_W'(SINE_N) - idx_r : idx_r;
    idx_c   = quad[0] ? idx_r : IDX_W'(SINE_N) - idx_r;
    s_mag   = SINE_ROM[idx_s];
    c_mag   = SINE_ROM[idx_c];
    sin_d   = quad[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
    cos_d   = (quad[1] ^ quad[0]) ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});
  end

  logic signed [VEL_W-1:0]  s1_vx_q;
  logic signed [VEL_W-1:0]  s1_vy_q;
  logic signed [VEL_W-1:0]  s1_w_q;
  logic signed [TRIG_W-1:0] s1_sin_q;
  logic signed [TRIG_W-1:0] s1_cos_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_vx_q  <= data_i.vel_x;
      s1_vy_q  <= data_i.vel_y;
      s1_w_q   <= data_i.yaw_rate;
      s1_sin_q <= sin_d;
      s1_cos_q <= cos_d;
    end
  end

  // Stage 2: four rotation products and the yaw moment
  logic signed [PROD_W-1:0] xc_d;
  logic signed [PROD_W-1:0] ys_d;
  logic signed [PROD_W-1:0] xs_d;
  logic signed [PROD_W-1:0] yc_d;
  logic signed [OW_W-1:0]   ow_d;

  always_comb begin
    xc_d = s1_vx_q * s1_cos_q;
    ys_d = s1_vy_q * s1_sin_q;
    xs_d = s1_vx_q * s1_sin_q;
    yc_d = s1_vy_q * s1_cos_q;
    ow_d = $signed({1'b0, ofs_i}) * s1_w_q;
  end

  logic signed [PROD_W-1:0] s2_xc_q;
  logic signed [PROD_W-1:0] s2_ys_q;
  logic signed [PROD_W-1:0] s2_xs_q;
  logic signed [PROD_W-1:0] s2_yc_q;
  logic signed [OW_W-1:0]   s2_ow_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_xc_q <= xc_d;
      s2_ys_q <= ys_d;
      s2_xs_q <= xs_d;
      s2_yc_q <= yc_d;
      s2_ow_q <= ow_d;
    end
  end

  // Stage 3: px = vx*c + vy*s, py = vy*c - vx*s
  rot_t rot_d;
  rot_t rot_q;

  always_comb begin
    rot_d.px = ROT_W'(s2_xc_q) + ROT_W'(s2_ys_q);
    rot_d.py = ROT_W'(s2_yc_q) - ROT_W'(s2_xs_q);
    rot_d.ow = s2_ow_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      rot_q <= rot_d;
    end
  end

  assign data_o = rot_q;

endmodule

`default_nettype wire

### rtl/owsm_mix.sv
// owsm_mix: four wheel surface speeds from the robot-frame velocity and yaw term.
// Four register stages ending in the rounded magnitude ahead of the /125 step.
// Depends on owsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module owsm_mix import owsm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire rot_t data_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output mix_t      data_o
);

  logic [3:0] vld_q;
  logic [4:0] adv;

  always_comb begin
    adv[4] = ready_i;
    adv[3] = !vld_q[3] || adv[4];
    adv[2] = !vld_q[2] || adv[3];
    adv[1] = !vld_q[1] || adv[2];
    adv[0] = !vld_q[0] || adv[1];
  end

  assign ready_o = adv[0];
  assign valid_o = vld_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
      if (adv[3]) vld_q[3] <= vld_q[2];
    end
  end

  // Stage 1: 0.866 term
  logic signed [T_W-1:0]   t_d;
  logic signed [T_W-1:0]   m1_t_q;
  logic signed [ROT_W-1:0] m1_px_q;
  logic signed [OW_W-1:0]  m1_ow_q;

  assign t_d = data_i.py * COEF_SQ3H_HALF;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      m1_t_q  <= t_d;
      m1_px_q <= data_i.px;
      m1_ow_q <= data_i.ow;
    end
  end

  // Stage 2: halved Q16 mix sums, yaw term aligned
  logic signed [A_W-1:0] a_one;
  logic signed [A_W-1:0] a_half;
  logic signed [A_W-1:0] a_d [NUM_WHEELS];
  logic signed [Q_W-1:0] dw_d;

  always_comb begin
    a_one  = A_W'(m1_px_q) <<< ONE_SH;
    a_half = A_W'(m1_px_q) <<< HALF_SH;
    a_d[0] = a_one;
    a_d[1] = A_W'(m1_t_q) - a_half;
    a_d[2] = -A_W'(m1_t_q) - a_half;
    a_d[3] = a_one;
    dw_d   = Q_W'(m1_ow_q) <<< DW_SH;
  end

  logic signed [A_W-1:0] m2_a_q [NUM_WHEELS];
  logic signed [Q_W-1:0] m2_dw_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      m2_a_q  <= a_d;
      m2_dw_q <= dw_d;
    end
  end

  // Stage 3: 125 * a -/+ yaw term, as (a << 7) - (a << 2) + a
  logic signed [Q_W-1:0] ae [NUM_WHEELS];
  logic signed [Q_W-1:0] q_d [NUM_WHEELS];

  always_comb begin
    for (int j = 0; j < NUM_WHEELS; j++) begin
      ae[j]  = Q_W'(m2_a_q[j]);
      q_d[j] = (ae[j] <<< 7) - (ae[j] <<< 2) + ae[j]
             + (YAW_PLUS[j] ? m2_dw_q : -m2_dw_q);
    end
  end

  logic signed [Q_W-1:0] m3_q_q [NUM_WHEELS];

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      m3_q_q <= q_d;
    end
  end

  // Stage 4: magnitude plus half divisor, power-of-two part of the divide
  logic [Q_W-1:0] mag [NUM_WHEELS];
  logic [Q_W-1:0] rsum [NUM_WHEELS];
  mix_t           mix_d;

  always_comb begin
    for (int j = 0; j < NUM_WHEELS; j++) begin
      mix_d.neg[j] = m3_q_q[j][Q_W-1];
      mag[j]       = mix_d.neg[j] ? Q_W'(-m3_q_q[j]) : Q_W'(m3_q_q[j]);
      rsum[j]      = mag[j] + ROUND_X;
      mix_d.x[j]   = rsum[j][X_SH +: X_W];
    end
  end

  mix_t m4_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      m4_q <= mix_d;
    end
  end

  assign data_o = m4_q;

endmodule

`default_nettype wire

### rtl/owsm_scale.sv
// owsm_scale: divide by 125, apply the RPM gain, round and saturate each wheel.
// Four register stages; the last one is the output register of the block.
// Depends on owsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module owsm_scale import owsm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire mix_t              data_i,
  input  wire logic [GAIN_W-1:0] gain_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output out_item_t              data_o
);

  localparam int MUL_W = X_W + RECIP_W;

  logic [3:0] vld_q;
  logic [4:0] adv;

  always_comb begin
    adv[4] = ready_i;
    adv[3] = !vld_q[3] || adv[4];
    adv[2] = !vld_q[2] || adv[3];
    adv[1] = !vld_q[1] || adv[2];
    adv[0] = !vld_q[0] || adv[1];
  end

  assign ready_o = adv[0];
  assign valid_o = vld_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
      if (adv[3]) vld_q[3] <= vld_q[2];
    end
  end

  // Stage 1: reciprocal estimate of x / 125, low by at most one
  logic [MUL_W-1:0] prd [NUM_WHEELS];
  logic [QT_W-1:0]  q0_d [NUM_WHEELS];

  always_comb begin
    for (int j = 0; j < NUM_WHEELS; j++) begin
      prd[j]  = MUL_W'(data_i.x[j]) * MUL_W'(RECIP_125);
      q0_d[j] = prd[j][X_W +: QT_W];
    end
  end

  logic [QT_W-1:0]       s1_q0_q [NUM_WHEELS];
  logic [NUM_WHEELS-1:0][X_W-1:0] s1_x_q;
  logic [NUM_WHEELS-1:0] s1_neg_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_q0_q  <= q0_d;
      s1_x_q   <= data_i.x;
      s1_neg_q <= data_i.neg;
    end
  end

  // Stage 2: remainder correction, then sign -> surface speed in Q8 mm/s
  logic [X_W-1:0]           rem [NUM_WHEELS];
  logic [QT_W-1:0]          qc [NUM_WHEELS];
  logic signed [SURF_W-1:0] surf_d [NUM_WHEELS];

  always_comb begin
    for (int j = 0; j < NUM_WHEELS; j++) begin
      rem[j]    = s1_x_q[j] - X_W'(s1_q0_q[j] * X_W'(SPLIT_DIV));
      qc[j]     = s1_q0_q[j] + QT_W'(rem[j] >= X_W'(SPLIT_DIV));
      surf_d[j] = s1_neg_q[j] ? -$signed({1'b0, qc[j]}) : $signed({1'b0, qc[j]});
    end
  end

  logic signed [SURF_W-1:0] s2_surf_q [NUM_WHEELS];

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_surf_q <= surf_d;
    end
  end

  // Stage 3: gain product
  logic signed [PRD_W-1:0] p_d [NUM_WHEELS];

  always_comb begin
    for (int j = 0; j < NUM_WHEELS; j++) begin
      p_d[j] = s2_surf_q[j] * $signed({1'b0, gain_i});
    end
  end

  logic signed [PRD_W-1:0] s3_p_q [NUM_WHEELS];

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s3_p_q <= p_d;
    end
  end

  // Stage 4: drop 24 bits rounding half away from zero, saturate to 24 bits
  localparam logic [RND_W-1:0] LIM = RND_W'(1) << (WHEEL_W - 1);

  logic                      pneg [NUM_WHEELS];
  logic [PRD_W-1:0]          pmag [NUM_WHEELS];
  logic [PRD_W-1:0]          psum [NUM_WHEELS];
  logic [RND_W-1:0]          rnd [NUM_WHEELS];
  logic signed [WHEEL_W-1:0] whl [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]     clip;
  out_item_t                 out_d;

  always_comb begin
    for (int j = 0; j < NUM_WHEELS; j++) begin
      pneg[j] = s3_p_q[j][PRD_W-1];
      pmag[j] = pneg[j] ? PRD_W'(-s3_p_q[j]) : PRD_W'(s3_p_q[j]);
      psum[j] = pmag[j] + (PRD_W'(1) << (OUT_SH - 1));
      rnd[j]  = psum[j][OUT_SH +: RND_W];
      if (pneg[j]) begin
        clip[j] = (rnd[j] > LIM);
        whl[j]  = clip[j] ? SAT_MIN : -$signed(rnd[j][WHEEL_W-1:0]);
      end else begin
        clip[j] = (rnd[j] >= LIM);
        whl[j]  = clip[j] ? SAT_MAX : $signed(rnd[j][WHEEL_W-1:0]);
      end
    end
    out_d.wheel_one   = whl[0];
    out_d.wheel_two   = whl[1];
    out_d.wheel_three = whl[2];
    out_d.wheel_four  = whl[3];
    out_d.clipped     = |clip;
  end

  out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      out_q <= out_d;
    end
  end

  assign data_o = out_q;

endmodule

`default_nettype wire
